[rtl/core/binary_mask_conv3x3_wrap_defines.svh]
// ----------------------------------------------------------------------------
// binary_mask_conv3x3_wrap_defines
// assertion macros shared by the mask convolution block
// ----------------------------------------------------------------------------
`ifndef BINARY_MASK_CONV3X3_WRAP_DEFINES_SVH
`define BINARY_MASK_CONV3X3_WRAP_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset, on clk and rst_n of the enclosing module
`define BMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define BMC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMC_ASSERT(lbl, prop, msg)
`define BMC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[rtl/core/bmc_pkg.sv]
// ----------------------------------------------------------------------------
// bmc_pkg
// types, sizes and microcode program of the mask convolution block
// ----------------------------------------------------------------------------
package bmc_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);

    localparam int POS_W   = 8;
    localparam int SIZE_W  = 9;
    localparam int COEF_W  = 4;
    localparam int NCOEF   = 9;
    localparam int KERN_W  = COEF_W * NCOEF;
    localparam int KIDX_W  = 4;
    localparam int ACC_W   = 8;
    localparam int CIDX_W  = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_KERNEL_COEFFS = 2'd2;

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t S_FETCH    = 4'd0;
    localparam step_t S_DISP     = 4'd1;
    localparam step_t S_RD1      = 4'd2;
    localparam step_t S_RD2      = 4'd3;
    localparam step_t S_RD3      = 4'd4;
    localparam step_t S_RD4      = 4'd5;
    localparam step_t S_RD5      = 4'd6;
    localparam step_t S_RD6      = 4'd7;
    localparam step_t S_RD7      = 4'd8;
    localparam step_t S_RD8      = 4'd9;
    localparam step_t S_ACC_LAST = 4'd10;
    localparam step_t S_EMIT     = 4'd11;
    localparam step_t S_WRITE    = 4'd12;

    typedef enum logic [2:0] {
        J_NEXT,
        J_WAIT_IN,
        J_DISPATCH,
        J_WAIT_OUT,
        J_GOTO
    } jump_t;

    typedef struct packed {
        logic       in_rdy;
        logic       mem_rd;
        logic       mem_wr;
        logic       acc_clr;
        logic       acc_add;
        logic       out_load;
        logic [1:0] nb_dx;
        logic [1:0] nb_dy;
        jump_t      jump;
        step_t      target;
    } ucode_t;

    typedef struct packed {
        logic in_range;
        logic is_query;
        logic out_free;
    } dp_status_t;

    // control store
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t uc;
        uc = '{in_rdy: 1'b0, mem_rd: 1'b0, mem_wr: 1'b0, acc_clr: 1'b0,
               acc_add: 1'b0, out_load: 1'b0, nb_dx: 2'd1, nb_dy: 2'd1,
               jump: J_NEXT, target: S_FETCH};
        case (s)
            S_FETCH:
            begin
                uc.in_rdy = 1'b1;
                uc.jump   = J_WAIT_IN;
            end
            S_DISP:
            begin
                uc.mem_rd  = 1'b1;
                uc.acc_clr = 1'b1;
                uc.nb_dx   = 2'd0;
                uc.nb_dy   = 2'd0;
                uc.jump    = J_DISPATCH;
            end
            S_RD1:
            begin
                uc.mem_rd = 1'b1; uc.acc_add = 1'b1; uc.nb_dx = 2'd1; uc.nb_dy = 2'd0;
            end
            S_RD2:
            begin
                uc.mem_rd = 1'b1; uc.acc_add = 1'b1; uc.nb_dx = 2'd2; uc.nb_dy = 2'd0;
            end
            S_RD3:
            begin
                uc.mem_rd = 1'b1; uc.acc_add = 1'b1; uc.nb_dx = 2'd0; uc.nb_dy = 2'd1;
            end
            S_RD4:
            begin
                uc.mem_rd = 1'b1; uc.acc_add = 1'b1; uc.nb_dx = 2'd1; uc.nb_dy = 2'd1;
            end
            S_RD5:
            begin
                uc.mem_rd = 1'b1; uc.acc_add = 1'b1; uc.nb_dx = 2'd2; uc.nb_dy = 2'd1;
            end
            S_RD6:
            begin
                uc.mem_rd = 1'b1; uc.acc_add = 1'b1; uc.nb_dx = 2'd0; uc.nb_dy = 2'd2;
            end
            S_RD7:
            begin
                uc.mem_rd = 1'b1; uc.acc_add = 1'b1; uc.nb_dx = 2'd1; uc.nb_dy = 2'd2;
            end
            S_RD8:
            begin
                uc.mem_rd = 1'b1; uc.acc_add = 1'b1; uc.nb_dx = 2'd2; uc.nb_dy = 2'd2;
            end
            S_ACC_LAST:
            begin
                uc.acc_add = 1'b1;
            end
            S_EMIT:
            begin
                uc.out_load = 1'b1;
                uc.jump     = J_WAIT_OUT;
                uc.target   = S_FETCH;
            end
            S_WRITE:
            begin
                uc.mem_wr = 1'b1;
                uc.jump   = J_GOTO;
                uc.target = S_FETCH;
            end
            default:
            begin
                uc.jump   = J_GOTO;
                uc.target = S_FETCH;
            end
        endcase
        return uc;
    endfunction

endpackage

[rtl/core/bmc_sequencer.sv]
// ----------------------------------------------------------------------------
// bmc_sequencer
// step counter, control store fetch and conditional jumps
// ----------------------------------------------------------------------------
`include "binary_mask_conv3x3_wrap_defines.svh"

module bmc_sequencer
    import bmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  dp_status_t status,
    output ucode_t     ctrl
);

    step_t step_reg;
    step_t step_next;

    assign ctrl = ucode_rom(step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        case (ctrl.jump)
            J_NEXT:
            begin
                step_next = step_reg + step_t'(1);
            end
            J_WAIT_IN:
            begin
                step_next = in_valid ? step_reg + step_t'(1) : step_reg;
            end
            J_DISPATCH:
            begin
                if (!status.in_range)
                begin
                    step_next = S_FETCH;
                end
                else if (!status.is_query)
                begin
                    step_next = S_WRITE;
                end
                else
                begin
                    step_next = step_reg + step_t'(1);
                end
            end
            J_WAIT_OUT:
            begin
                step_next = status.out_free ? ctrl.target : step_reg;
            end
            J_GOTO:
            begin
                step_next = ctrl.target;
            end
            default:
            begin
                step_next = S_FETCH;
            end
        endcase
    end

    `BMC_ASSERT_RST(a_reset_step, !rst_n |-> step_reg == S_FETCH, "step not cleared in reset")
    `BMC_ASSERT(a_accept_dispatch, in_valid && ctrl.in_rdy |=> step_reg == S_DISP,
        "accepted beat not dispatched")
    `BMC_ASSERT(a_write_after_disp, step_reg == S_WRITE |-> $past(step_reg) == S_DISP,
        "mask write not entered from dispatch")
    `BMC_ASSERT(a_step_range, step_reg <= S_WRITE, "step counter out of program")

endmodule

[rtl/core/bmc_datapath.sv]
// ----------------------------------------------------------------------------
// bmc_datapath
// item latch, wrapped neighbour addressing, mask memory, accumulator, output
// ----------------------------------------------------------------------------
`include "binary_mask_conv3x3_wrap_defines.svh"

module bmc_datapath
    import bmc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ucode_t                   ctrl,
    output dp_status_t               status,
    input  logic [SIZE_W-1:0]        frame_width,
    input  logic [SIZE_W-1:0]        frame_height,
    input  logic [KERN_W-1:0]        kernel_coeffs,
    input  logic                     in_valid,
    input  logic                     kind,
    input  logic [POS_W-1:0]         pos_x,
    input  logic [POS_W-1:0]         pos_y,
    input  logic                     mask_bit,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [ACC_W-1:0]  conv_value
);

    logic                     kind_reg;
    logic [POS_W-1:0]         x_reg;
    logic [POS_W-1:0]         y_reg;
    logic                     bit_reg;
    logic [SIZE_W-1:0]        eff_w;
    logic [SIZE_W-1:0]        eff_h;
    logic [SIZE_W-1:0]        nx;
    logic [SIZE_W-1:0]        ny;
    logic [ADDR_W-1:0]        addr;
    logic                     mem_q [0:DEPTH-1];
    logic                     rd_reg;
    logic [KIDX_W-1:0]        k_reg;
    logic [KIDX_W-1:0]        k_next;
    logic [COEF_W-1:0]        coef;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [ACC_W-1:0]  conv_value_reg;
    logic                     in_fire;
    logic                     out_fire;

    // neighbour coordinate p + d - 1 folded into 0..n-1
    function automatic logic [SIZE_W-1:0] wrap_coord(input logic [POS_W-1:0] p,
                                                     input logic [1:0] d,
                                                     input logic [SIZE_W-1:0] n);
        logic [SIZE_W:0] q;
        q = {2'b00, p} + {{(SIZE_W-1){1'b0}}, d};
        if (q == '0)
        begin
            return n - SIZE_W'(1);
        end
        q = q - (SIZE_W+1)'(1);
        if (q >= {1'b0, n})
        begin
            q = q - {1'b0, n};
        end
        return q[SIZE_W-1:0];
    endfunction

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                   input int limit);
        if (r == '0)
        begin
            return SIZE_W'(1);
        end
        if (int'(r) > limit)
        begin
            return SIZE_W'(limit);
        end
        return r;
    endfunction

    assign in_fire  = in_valid && ctrl.in_rdy;
    assign out_fire = out_valid_reg && out_ready;

    assign eff_w = eff_size(frame_width, MAX_WIDTH);
    assign eff_h = eff_size(frame_height, MAX_HEIGHT);

    assign status.in_range = ({1'b0, x_reg} < eff_w) && ({1'b0, y_reg} < eff_h);
    assign status.is_query = (kind_reg == KIND_QUERY);
    assign status.out_free = !out_valid_reg || out_ready;

    // item latch
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg <= kind;
            x_reg    <= pos_x;
            y_reg    <= pos_y;
            bit_reg  <= mask_bit;
        end
    end

    // fixed-pitch address of the selected neighbour
    assign nx   = wrap_coord(x_reg, ctrl.nb_dx, eff_w);
    assign ny   = wrap_coord(y_reg, ctrl.nb_dy, eff_h);
    assign addr = ADDR_W'(ny) * ADDR_W'(MAX_WIDTH) + ADDR_W'(nx);

    // single-port mask memory
    always_ff @(posedge clk)
    begin
        if (ctrl.mem_wr)
        begin
            mem_q[addr] <= bit_reg;
        end
        if (ctrl.mem_rd)
        begin
            rd_reg <= mem_q[addr];
        end
    end

    // coefficient index is registered together with the read data
    assign k_next = {2'b00, ctrl.nb_dx} * KIDX_W'(3) + {2'b00, ctrl.nb_dy};

    always_ff @(posedge clk)
    begin
        if (ctrl.mem_rd)
        begin
            k_reg <= k_next;
        end
    end

    assign coef = kernel_coeffs[{k_reg, 2'b00} +: COEF_W];
    assign term = rd_reg ? {{(ACC_W-COEF_W){coef[COEF_W-1]}}, coef} : '0;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_clr)
        begin
            acc_next = '0;
        end
        else if (ctrl.acc_add)
        begin
            acc_next = acc_reg + term;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.out_load && status.out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load && status.out_free)
        begin
            conv_value_reg <= acc_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign conv_value = conv_value_reg;

    `BMC_ASSERT(a_write_kind, ctrl.mem_wr |-> kind_reg == KIND_WRITE,
        "mask write issued for a query beat")
    `BMC_ASSERT(a_out_from_load, $rose(out_valid_reg) |-> $past(ctrl.out_load),
        "result raised without a load step")
    `BMC_ASSERT(a_acc_bound, (acc_reg >= -8'sd72) && (acc_reg <= 8'sd72),
        "accumulator out of kernel range")

endmodule

[rtl/core/binary_mask_conv3x3_wrap.sv]
// ----------------------------------------------------------------------------
// binary_mask_conv3x3_wrap
// one-bit mask frame with a wrapped 3x3 kernel sum, microcoded control
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): kind 0 stores mask_bit at (pos_x, pos_y),
//   kind 1 asks for the weighted sum of the nine toroidally wrapped neighbours
//   output channel (out_valid/out_ready): one conv_value beat per query
//   configuration channel (cfg_valid/cfg_ready): cfg_index selects frame width,
//   frame height or the packed kernel, cfg_data carries the value; always ready
//   a query runs from acceptance to the next ready through dispatch, nine
//   reads of the single-port mask memory one per cycle with the accumulate one
//   step behind, and a load into the output register
//   a mask write goes through dispatch and a write step; a beat outside
//   the frame is dropped at dispatch; the result shows after its load step
//   a result waiting in the output register does not block the next beat; a
//   second query stalls in its load step until the receiver takes the first
//   reset clears the sequencer, output valid and kernel, sets frame size to
//   256x256; the mask memory is not cleared and holds nothing until written
// ----------------------------------------------------------------------------
module binary_mask_conv3x3_wrap
    import bmc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     kind,
    input  logic [POS_W-1:0]         pos_x,
    input  logic [POS_W-1:0]         pos_y,
    input  logic                     mask_bit,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [ACC_W-1:0]  conv_value,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CIDX_W-1:0]        cfg_index,
    input  logic [KERN_W-1:0]        cfg_data
);

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [KERN_W-1:0] coeffs_reg;
    ucode_t            ctrl;
    dp_status_t        status;

    assign cfg_ready = 1'b1;

    // configuration registers, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
            coeffs_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    width_reg <= cfg_data[SIZE_W-1:0];
                end
                REG_FRAME_HEIGHT:
                begin
                    height_reg <= cfg_data[SIZE_W-1:0];
                end
                REG_KERNEL_COEFFS:
                begin
                    coeffs_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    bmc_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .ctrl     (ctrl)
    );

    bmc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .status        (status),
        .frame_width   (width_reg),
        .frame_height  (height_reg),
        .kernel_coeffs (coeffs_reg),
        .in_valid      (in_valid),
        .kind          (kind),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .mask_bit      (mask_bit),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .conv_value    (conv_value)
    );

    assign in_ready = ctrl.in_rdy;

endmodule
